### design/u2u_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Word types, the job passed from the front end to the back end, and the
// constants of the decoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_string;
    } in_word_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_of_run;
        logic        string_done;
    } out_word_t;

    // One decoded byte: one or two code units and the end-of-string mark.
    typedef struct packed {
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic        two_units;
        logic        done;
    } job_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] REPL_CHAR   = 16'hFFFD;
    localparam logic [15:0] HIGH_OFFSET = 16'hD7C0;
    localparam logic [5:0]  LOW_PREFIX  = 6'b110111;
    localparam logic [7:0]  CONT_LOW    = 8'h80;
    localparam logic [7:0]  CONT_HIGH   = 8'hBF;
    localparam logic [7:0]  E0_LOW      = 8'hA0;
    localparam logic [7:0]  ED_HIGH     = 8'h9F;
    localparam logic [7:0]  F0_LOW      = 8'h90;
    localparam logic [7:0]  F4_HIGH     = 8'h8F;

endpackage

### design/utf8_to_utf16_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder
// Takes one byte per cycle while the job queue is not full; each byte's
// code units pass through the job queue and then the output register to
// the result ports. A byte that yields a surrogate pair or a replacement
// plus a unit fills the output register once per code unit; a four-entry
// job queue absorbs these bursts. Reset clears the sequence state and
// empties the queue and the output register.
module utf8_to_utf16_decoder_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  u2u_pkg::in_word_t  item,
    output logic               empty,
    input  logic               pop,
    output u2u_pkg::out_word_t result
);
    import u2u_pkg::*;

    job_t front_job;
    job_t head_job;
    logic front_valid;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign full = q_full;

    u2u_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (push && !q_full),
        .item      (item),
        .job_valid (front_valid),
        .job       (front_job)
    );

    u2u_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_job  (front_job),
        .rd_en   (q_pop),
        .rd_job  (head_job),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    u2u_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

### design/u2u_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder front end
// Classifies each byte against the pending sequence, keeps the sequence
// state and turns every byte that yields code units into one job.
// ----------------------------------------------------------------------------
module u2u_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  u2u_pkg::in_word_t item,
    output logic             job_valid,
    output u2u_pkg::job_t    job
);
    import u2u_pkg::*;

    logic [20:0] partial_reg, partial_next;
    logic [1:0]  need_reg, need_next;
    logic [1:0]  seen_reg, seen_next;
    logic [7:0]  low_reg, low_next;
    logic [7:0]  high_reg, high_next;

    always_comb
    begin
        logic [7:0]  b;
        logic [1:0]  n;
        logic [15:0] u0;
        logic [15:0] u1;
        logic        lead;
        logic        lead_emit;
        logic [15:0] lead_unit;
        logic [1:0]  lead_need;
        logic [1:0]  seen_inc;
        logic [20:0] cp;

        b         = item.byte_in;
        n         = 2'd0;
        u0        = REPL_CHAR;
        u1        = REPL_CHAR;
        lead      = 1'b0;
        lead_emit = 1'b0;
        lead_unit = REPL_CHAR;
        lead_need = 2'd0;
        seen_inc  = seen_reg + 2'd1;
        cp        = {partial_reg[14:0], b[5:0]};

        partial_next = partial_reg;
        need_next    = need_reg;
        seen_next    = seen_reg;
        low_next     = low_reg;
        high_next    = high_reg;

        if (need_reg == 2'd0)
        begin
            lead = 1'b1;
        end
        else if (b < low_reg || b > high_reg)
        begin
            u0 = REPL_CHAR;
            n  = 2'd1;
            partial_next = '0;
            need_next    = 2'd0;
            seen_next    = 2'd0;
            low_next     = CONT_LOW;
            high_next    = CONT_HIGH;
            lead = 1'b1;
        end
        else
        begin
            low_next     = CONT_LOW;
            high_next    = CONT_HIGH;
            partial_next = cp;
            seen_next    = seen_inc;
            if (seen_inc == need_reg)
            begin
                if (cp[20:16] == 5'd0)
                begin
                    u0 = cp[15:0];
                    n  = 2'd1;
                end
                else
                begin
                    u0 = 16'({5'd0, cp[20:10]}) + HIGH_OFFSET;
                    u1 = {LOW_PREFIX, cp[9:0]};
                    n  = 2'd2;
                end
                partial_next = '0;
                need_next    = 2'd0;
                seen_next    = 2'd0;
            end
        end

        if (lead)
        begin
            if (b[7] == 1'b0)
            begin
                lead_emit = 1'b1;
                lead_unit = {8'd0, b};
            end
            else if (b[6] == 1'b0)
            begin
                lead_emit = 1'b1;
            end
            else if (b >= 8'hC2 && b <= 8'hDF)
            begin
                lead_need = 2'd1;
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                lead_need = 2'd2;
            end
            else if (b >= 8'hF0 && b <= 8'hF4)
            begin
                lead_need = 2'd3;
            end
            else
            begin
                lead_emit = 1'b1;
            end

            if (lead_emit)
            begin
                if (n == 2'd0)
                begin
                    u0 = lead_unit;
                end
                else
                begin
                    u1 = lead_unit;
                end
                n = n + 2'd1;
            end
            else
            begin
                need_next = lead_need;
                seen_next = 2'd0;
                low_next  = CONT_LOW;
                high_next = CONT_HIGH;
                unique case (lead_need)
                    2'd1:    partial_next = {16'd0, b[4:0]};
                    2'd2:    partial_next = {17'd0, b[3:0]};
                    default: partial_next = {18'd0, b[2:0]};
                endcase
                if (b == 8'hE0)
                begin
                    low_next = E0_LOW;
                end
                else if (b == 8'hED)
                begin
                    high_next = ED_HIGH;
                end
                else if (b == 8'hF0)
                begin
                    low_next = F0_LOW;
                end
                else if (b == 8'hF4)
                begin
                    high_next = F4_HIGH;
                end
            end
        end

        if (item.end_of_string)
        begin
            if (need_next != 2'd0)
            begin
                if (n == 2'd0)
                begin
                    u0 = REPL_CHAR;
                end
                else
                begin
                    u1 = REPL_CHAR;
                end
                n = n + 2'd1;
            end
            partial_next = '0;
            need_next    = 2'd0;
            seen_next    = 2'd0;
            low_next     = CONT_LOW;
            high_next    = CONT_HIGH;
        end

        job_valid     = accept && (n != 2'd0);
        job.unit0     = u0;
        job.unit1     = u1;
        job.two_units = (n == 2'd2);
        job.done      = item.end_of_string;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            need_reg    <= 2'd0;
            seen_reg    <= 2'd0;
            low_reg     <= CONT_LOW;
            high_reg    <= CONT_HIGH;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            need_reg    <= need_next;
            seen_reg    <= seen_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
        end
    end

endmodule

### design/u2u_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder job queue
// A short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module u2u_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  u2u_pkg::job_t wr_job,
    input  logic          rd_en,
    output u2u_pkg::job_t rd_job,
    output logic          q_full,
    output logic          q_empty
);
    import u2u_pkg::*;

    job_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_wr;
    logic                   do_rd;

    assign q_full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/u2u_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder back end
// Splits each job into its code units and holds the oldest one in the
// output register until it is popped.
// ----------------------------------------------------------------------------
module u2u_back (
    input  logic               clk,
    input  logic               rst_n,
    input  u2u_pkg::job_t      head_job,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output u2u_pkg::out_word_t result
);
    import u2u_pkg::*;

    out_word_t out_reg, out_next;
    logic      valid_reg, valid_next;
    logic      sel_reg, sel_next;
    logic      load;

    assign empty  = !valid_reg;
    assign result = out_reg;
    assign load   = (!valid_reg || pop) && !q_empty;

    always_comb
    begin
        out_next   = out_reg;
        valid_next = valid_reg;
        sel_next   = sel_reg;
        q_pop      = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            if (!sel_reg && head_job.two_units)
            begin
                out_next.code_unit   = head_job.unit0;
                out_next.last_of_run = 1'b0;
                out_next.string_done = 1'b0;
                sel_next             = 1'b1;
            end
            else
            begin
                out_next.code_unit   = sel_reg ? head_job.unit1 : head_job.unit0;
                out_next.last_of_run = 1'b1;
                out_next.string_done = head_job.done;
                sel_next             = 1'b0;
                q_pop                = 1'b1;
            end
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

endmodule
